// ===== hdl/process_ready_queue_scheduler_assert.svh =====
// Assertion macros of the checker module of the ready queue scheduler.
`ifndef PROCESS_READY_QUEUE_SCHEDULER_ASSERT_SVH
`define PROCESS_READY_QUEUE_SCHEDULER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define PRQS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define PRQS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/prqs_pkg.sv =====
// Shared constants, types and codes of the ready queue scheduler.
package prqs_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned ID_W        = 8;
  localparam int unsigned BURST_W     = 16;
  localparam int unsigned POLICY_W    = 2;

  localparam int unsigned S_TDATA_W   = 56;
  localparam int unsigned S_TUSER_W   = 1;
  localparam int unsigned M_TDATA_W   = 40;
  localparam int unsigned M_TUSER_W   = 2;

  // Scheduling policies; the unused code behaves as first come first served.
  typedef enum logic [POLICY_W-1:0] {
    POL_FCFS = 2'd0,
    POL_RR   = 2'd1,
    POL_SRTF = 2'd2
  } policy_e;

  // One queue entry.
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] burst;
  } entry_t;

  // Operations of the queue controller.
  typedef enum logic [1:0] {
    Q_OP_PUSH,
    Q_OP_INSERT,
    Q_OP_POP
  } q_op_e;

  typedef struct packed {
    logic   req;
    q_op_e  op;
    entry_t item;
  } q_cmd_t;

  typedef struct packed {
    logic   done;
    logic   ovf;
    logic   empty;
    entry_t item;
  } q_stat_t;

  typedef enum logic [2:0] {
    Q_IDLE,
    Q_SCAN_RD,
    Q_SCAN_CMP,
    Q_SHIFT_RD,
    Q_SHIFT_WR,
    Q_POP_RD
  } q_state_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NEW,
    S_RUN,
    S_POP,
    S_DONE
  } sched_state_e;

endpackage

// ===== hdl/process_ready_queue_scheduler.sv =====
// Top level of the ready queue scheduler: event decode, running slot and stream ports.
// Each accepted word is one scheduling event and yields one result word. After
// the accept cycle the event walks three steps (enqueue the new process, enqueue
// the running process, pop the queue front) and a result step, which waits while
// an earlier result still waits on m_axis. A shortest remaining time insert scans
// from the queue front to the insert point and then moves each entry behind it up
// one place, with one read and one write for every entry. The single-port queue
// memory and its one burst comparator make it walk the entries one at a time.
// s_axis_tready is high only between events; a result may wait on m_axis while the
// next event is taken.
module process_ready_queue_scheduler (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [prqs_pkg::POLICY_W-1:0]    cfg_data_i,    // policy
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // new_id[7:0], new_burst[23:8], time_remaining[39:24], running_burst[55:40]
  input  logic [prqs_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // has_new[0]
  input  logic [prqs_pkg::S_TUSER_W-1:0]   s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // run_id[7:0], run_burst[23:8], finished_id[31:24], overflow[32], zero[39:33]
  output logic [prqs_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // run_valid[0], finished_valid[1]
  output logic [prqs_pkg::M_TUSER_W-1:0]   m_axis_tuser
);
  import prqs_pkg::*;

  sched_state_e         state_q, state_d;
  logic [POLICY_W-1:0]  policy_q;

  logic                 run_present_q, run_present_d;
  logic [ID_W-1:0]      run_ident_q, run_ident_d;
  logic [BURST_W-1:0]   run_rem_q, run_rem_d;

  logic                 need_new_q, need_new_d;
  logic                 need_run_q, need_run_d;
  logic                 need_pop_q, need_pop_d;
  logic                 sorted_q, sorted_d;
  logic                 run_new_q, run_new_d;
  logic                 fin_q, fin_d;
  logic                 ovf_q, ovf_d;
  entry_t               new_q, new_d;
  logic [ID_W-1:0]      fin_id_q, fin_id_d;

  logic                 m_valid_q, m_valid_d;
  logic [M_TDATA_W-1:0] m_data_q, m_data_d;
  logic [M_TUSER_W-1:0] m_user_q, m_user_d;

  logic                 in_has_new;
  logic [ID_W-1:0]      in_new_id;
  logic [BURST_W-1:0]   in_new_burst;
  logic [BURST_W-1:0]   in_tr;
  logic [BURST_W-1:0]   in_rb;

  logic                 dec_new, dec_run, dec_pop, dec_sorted, dec_run_new, dec_fin;
  logic                 srtf_live;

  logic                 out_present;
  logic [ID_W-1:0]      out_ident;
  logic [BURST_W-1:0]   out_rem;

  q_cmd_t               q_cmd;
  q_stat_t              q_stat;

  // Input word fields.
  assign in_has_new   = s_axis_tuser[0];
  assign in_new_id    = s_axis_tdata[7:0];
  assign in_new_burst = s_axis_tdata[23:8];
  assign in_tr        = s_axis_tdata[39:24];
  assign in_rb        = s_axis_tdata[55:40];

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // Decide the queue steps of the incoming event from the policy and slot state.
  always_comb begin
    dec_new     = 1'b0;
    dec_run     = 1'b0;
    dec_pop     = 1'b0;
    dec_sorted  = 1'b0;
    dec_run_new = 1'b0;
    dec_fin     = 1'b0;
    srtf_live   = run_present_q && (in_tr != '0);

    unique case (policy_q)
      POL_RR: begin
        if (in_tr == '0) begin
          if (!run_present_q) begin
            dec_run_new = in_has_new;
          end else begin
            dec_new = in_has_new;
            dec_run = (in_rb != '0);
            dec_fin = (in_rb == '0);
            dec_pop = 1'b1;
          end
        end else begin
          dec_new = in_has_new;
        end
      end
      POL_SRTF: begin
        dec_sorted = 1'b1;
        if (!in_has_new) begin
          if ((in_tr == '0) && run_present_q) begin
            dec_fin = 1'b1;
            dec_pop = 1'b1;
          end
        end else if ((in_tr == '0) && !run_present_q) begin
          dec_run_new = 1'b1;
        end else begin
          // The expired process finishes and then the slot counts as empty.
          dec_fin = (in_tr == '0);
          if (in_tr > in_new_burst) begin
            dec_run     = srtf_live;
            dec_run_new = 1'b1;
          end else begin
            dec_new = 1'b1;
            dec_pop = !srtf_live;
          end
        end
      end
      default: begin
        if (!run_present_q) begin
          dec_run_new = in_has_new;
        end else begin
          dec_new = in_has_new;
          dec_fin = (in_tr == '0);
          dec_pop = (in_tr == '0);
        end
      end
    endcase
  end

  // Slot contents shown in the result.
  assign out_present = run_new_q ? 1'b1 : run_present_q;
  assign out_ident   = run_new_q ? new_q.id : run_ident_q;
  assign out_rem     = run_new_q ? new_q.burst : run_rem_q;

  // Event sequencer and queue requests.
  always_comb begin
    state_d       = state_q;
    run_present_d = run_present_q;
    run_ident_d   = run_ident_q;
    run_rem_d     = run_rem_q;
    need_new_d    = need_new_q;
    need_run_d    = need_run_q;
    need_pop_d    = need_pop_q;
    sorted_d      = sorted_q;
    run_new_d     = run_new_q;
    fin_d         = fin_q;
    new_d         = new_q;
    fin_id_d      = fin_id_q;
    ovf_d         = ovf_q | (q_stat.done & q_stat.ovf);
    m_valid_d     = m_valid_q;
    m_data_d      = m_data_q;
    m_user_d      = m_user_q;
    q_cmd         = '0;
    q_cmd.op      = sorted_q ? Q_OP_INSERT : Q_OP_PUSH;
    q_cmd.item    = new_q;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          need_new_d = dec_new;
          need_run_d = dec_run;
          need_pop_d = dec_pop;
          sorted_d   = dec_sorted;
          run_new_d  = dec_run_new;
          fin_d      = dec_fin;
          fin_id_d   = run_ident_q;
          new_d.id    = in_new_id;
          new_d.burst = in_new_burst;
          ovf_d      = 1'b0;
          if (run_present_q) begin
            run_rem_d = in_rb;
          end
          state_d = S_NEW;
        end
      end
      S_NEW: begin
        q_cmd.req = need_new_q;
        if (!need_new_q || q_stat.done) begin
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        q_cmd.req        = need_run_q;
        q_cmd.item.id    = run_ident_q;
        q_cmd.item.burst = run_rem_q;
        if (!need_run_q || q_stat.done) begin
          state_d = S_POP;
        end
      end
      S_POP: begin
        q_cmd.req = need_pop_q;
        q_cmd.op  = Q_OP_POP;
        if (need_pop_q && q_stat.done) begin
          run_present_d = !q_stat.empty;
          if (!q_stat.empty) begin
            run_ident_d = q_stat.item.id;
            run_rem_d   = q_stat.item.burst;
          end
        end
        if (!need_pop_q || q_stat.done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          run_present_d  = out_present;
          run_ident_d    = out_ident;
          run_rem_d      = out_rem;
          m_valid_d      = 1'b1;
          m_data_d       = '0;
          m_data_d[7:0]  = out_present ? out_ident : '0;
          m_data_d[23:8] = out_present ? out_rem : '0;
          m_data_d[31:24] = fin_q ? fin_id_q : '0;
          m_data_d[32]   = ovf_q;
          m_user_d[0]    = out_present;
          m_user_d[1]    = fin_q;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      policy_q      <= POL_FCFS;
      run_present_q <= 1'b0;
      run_ident_q   <= '0;
      run_rem_q     <= '0;
      need_new_q    <= 1'b0;
      need_run_q    <= 1'b0;
      need_pop_q    <= 1'b0;
      sorted_q      <= 1'b0;
      run_new_q     <= 1'b0;
      fin_q         <= 1'b0;
      ovf_q         <= 1'b0;
      m_valid_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        policy_q <= cfg_data_i;
      end
      run_present_q <= run_present_d;
      run_ident_q   <= run_ident_d;
      run_rem_q     <= run_rem_d;
      need_new_q    <= need_new_d;
      need_run_q    <= need_run_d;
      need_pop_q    <= need_pop_d;
      sorted_q      <= sorted_d;
      run_new_q     <= run_new_d;
      fin_q         <= fin_d;
      ovf_q         <= ovf_d;
      m_valid_q     <= m_valid_d;
    end
  end

  // Event payload and result word.
  always_ff @(posedge clk_i) begin
    new_q    <= new_d;
    fin_id_q <= fin_id_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  prqs_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (q_cmd),
    .stat_o (q_stat)
  );

endmodule

// ===== hdl/prqs_queue.sv =====
// Ready queue: ring buffer memory with a sequencer for push, sorted insert and pop.
module prqs_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  prqs_pkg::q_cmd_t cmd_i,
  output prqs_pkg::q_stat_t stat_o
);
  import prqs_pkg::*;

  q_state_e             state_q, state_d;
  logic [IDX_W-1:0]     head_q, head_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     idx_q, idx_d;
  logic [CNT_W-1:0]     pos_q, pos_d;

  entry_t               mem_q [QUEUE_DEPTH];
  entry_t               rdata_q;
  entry_t               wdata;
  logic [IDX_W-1:0]     raddr;
  logic [IDX_W-1:0]     waddr;
  logic                 we;
  logic                 full;

  // Offset from the head, wrapped around the ring.
  function automatic logic [IDX_W-1:0] ring_add(logic [IDX_W-1:0] base,
                                                logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  assign full = (count_q == CNT_W'(QUEUE_DEPTH));

  // Single-port storage with a registered read.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  // Sequencer: a sorted insert scans forward with the one burst comparator,
  // then moves the tail up one word at a time and writes the new word.
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    raddr       = head_q;
    waddr       = head_q;
    wdata       = cmd_i.item;
    we          = 1'b0;
    stat_o      = '0;
    stat_o.item = rdata_q;

    unique case (state_q)
      Q_IDLE: begin
        if (cmd_i.req) begin
          unique case (cmd_i.op)
            Q_OP_PUSH: begin
              stat_o.done = 1'b1;
              if (full) begin
                stat_o.ovf = 1'b1;
              end else begin
                we      = 1'b1;
                waddr   = ring_add(head_q, count_q);
                count_d = count_q + CNT_W'(1);
              end
            end
            Q_OP_INSERT: begin
              if (full) begin
                stat_o.done = 1'b1;
                stat_o.ovf  = 1'b1;
              end else begin
                idx_d   = '0;
                state_d = Q_SCAN_RD;
              end
            end
            Q_OP_POP: begin
              if (count_q == '0) begin
                stat_o.done  = 1'b1;
                stat_o.empty = 1'b1;
              end else begin
                raddr   = head_q;
                state_d = Q_POP_RD;
              end
            end
            default: begin
              stat_o.done = 1'b1;
            end
          endcase
        end
      end
      Q_SCAN_RD: begin
        if (idx_q == count_q) begin
          pos_d   = idx_q;
          state_d = Q_SHIFT_RD;
        end else begin
          raddr   = ring_add(head_q, idx_q);
          state_d = Q_SCAN_CMP;
        end
      end
      Q_SCAN_CMP: begin
        if (rdata_q.burst > cmd_i.item.burst) begin
          pos_d   = idx_q;
          idx_d   = count_q;
          state_d = Q_SHIFT_RD;
        end else begin
          idx_d   = idx_q + CNT_W'(1);
          state_d = Q_SCAN_RD;
        end
      end
      Q_SHIFT_RD: begin
        if (idx_q == pos_q) begin
          we          = 1'b1;
          waddr       = ring_add(head_q, pos_q);
          count_d     = count_q + CNT_W'(1);
          stat_o.done = 1'b1;
          state_d     = Q_IDLE;
        end else begin
          raddr   = ring_add(head_q, idx_q - CNT_W'(1));
          state_d = Q_SHIFT_WR;
        end
      end
      Q_SHIFT_WR: begin
        we      = 1'b1;
        waddr   = ring_add(head_q, idx_q);
        wdata   = rdata_q;
        idx_d   = idx_q - CNT_W'(1);
        state_d = Q_SHIFT_RD;
      end
      Q_POP_RD: begin
        stat_o.done = 1'b1;
        head_d      = ring_add(head_q, CNT_W'(1));
        count_d     = count_q - CNT_W'(1);
        state_d     = Q_IDLE;
      end
      default: begin
        state_d = Q_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Q_IDLE;
      head_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // Scan and shift positions.
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    pos_q <= pos_d;
  end

endmodule

// ===== hdl/prqs_checker.sv =====
// Port-level checker of the ready queue scheduler, bound to the top level.
`include "process_ready_queue_scheduler_assert.svh"

module prqs_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [prqs_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [prqs_pkg::M_TUSER_W-1:0] m_axis_tuser
);

  // A stalled result word holds.
  `PRQS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result word changed")

  // With no running process the slot fields read as zero.
  `PRQS_ASSERT_NOW(a_idle_slot_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[23:0] == 24'd0, "run fields not zero without a running process")

  // With nothing finished the finished id reads as zero.
  `PRQS_ASSERT_NOW(a_fin_id_zero, m_axis_tvalid && !m_axis_tuser[1], m_axis_tdata[31:24] == 8'd0, "finished id not zero without a finished process")

  // An event keeps the block busy for at least the following cycle.
  `PRQS_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input ready right after an accepted event")

endmodule

bind process_ready_queue_scheduler prqs_checker u_prqs_checker (.*);

// ===== verif/tb_process_ready_queue_scheduler.sv =====
// Self-checking testbench of the ready queue scheduler under all policies and random flow.
`timescale 1ns / 100ps

module tb_process_ready_queue_scheduler;
  import prqs_pkg::*;

  // The spare policy code behaves as first come first served.
  localparam logic [POLICY_W-1:0] POL_SPARE = 2'd3;

  localparam int unsigned DIR_ROWS       = 25;
  localparam int unsigned RAND_ITEMS     = 550;
  localparam int unsigned RAND_PHASES    = 6;
  localparam int unsigned SINK_HOLD      = 400;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned TAIL_CYCLES    = 40;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned MAX_REPORTS    = 60;

  typedef enum int unsigned {
    LOAD_FILL,
    LOAD_DRAIN,
    LOAD_MIX
  } load_mode_e;

  // One scheduling event as the sender offers it.
  typedef struct packed {
    logic               has_new;
    logic [ID_W-1:0]    new_id;
    logic [BURST_W-1:0] new_burst;
    logic [BURST_W-1:0] time_left;
    logic [BURST_W-1:0] run_burst;
  } sched_event_t;

  // One scheduling outcome as the block reports it.
  typedef struct packed {
    logic               run_valid;
    logic [ID_W-1:0]    run_id;
    logic [BURST_W-1:0] run_burst;
    logic               fin_valid;
    logic [ID_W-1:0]    fin_id;
    logic               overflow;
  } sched_result_t;

  // An offered event, with a hand-written outcome where typed is set.
  typedef struct packed {
    logic          typed;
    sched_event_t  ev;
    sched_result_t res;
  } sched_rec_t;

  typedef struct packed {
    logic [POLICY_W-1:0] pol;
    sched_rec_t          rec;
  } dir_row_t;

  localparam sched_result_t NO_RES = '0;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [POLICY_W-1:0]  cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [S_TUSER_W-1:0] s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [M_TUSER_W-1:0] m_axis_tuser;

  // Predicted state of the scheduler.
  entry_t              ready_q[$];
  logic                slot_busy  = 1'b0;
  entry_t              slot       = '0;
  logic [POLICY_W-1:0] cur_policy = POL_FCFS;
  logic                drop_flag;

  sched_rec_t    offered_events[$];
  sched_result_t pending_outcomes[$];

  int unsigned events_sent  = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles  = 0;
  int unsigned n_fail       = 0;
  int unsigned n_reports    = 0;
  bit          tx_steady    = 1'b0;
  bit          rx_steady    = 1'b0;
  bit          sink_hold_req = 1'b0;

  // Directed events: extremes, each policy, the spare code and the idle-slot cases.
  dir_row_t dir_tab [DIR_ROWS] = '{
    // Nothing runs: the running burst is ignored and nothing is reported.
    '{POL_FCFS, '{1'b1, '{1'b0, 8'h00, 16'h0000, 16'h0000, 16'hFFFF},
                        '{1'b0, 8'h00, 16'h0000, 1'b0, 8'h00, 1'b0}}},
    '{POL_FCFS, '{1'b1, '{1'b1, 8'hFF, 16'hFFFF, 16'hFFFF, 16'h0000},
                        '{1'b1, 8'hFF, 16'hFFFF, 1'b0, 8'h00, 1'b0}}},
    '{POL_FCFS, '{1'b1, '{1'b1, 8'h00, 16'h0000, 16'h0005, 16'h1234},
                        '{1'b1, 8'hFF, 16'h1234, 1'b0, 8'h00, 1'b0}}},
    '{POL_FCFS, '{1'b1, '{1'b0, 8'h00, 16'h0000, 16'h0000, 16'h0000},
                        '{1'b1, 8'h00, 16'h0000, 1'b1, 8'hFF, 1'b0}}},
    // Expiry with an empty queue leaves the slot empty.
    '{POL_FCFS, '{1'b1, '{1'b0, 8'h00, 16'h0000, 16'h0000, 16'hABCD},
                        '{1'b0, 8'h00, 16'h0000, 1'b1, 8'h00, 1'b0}}},
    '{POL_SPARE, '{1'b1, '{1'b1, 8'h42, 16'h0007, 16'h0003, 16'h0000},
                         '{1'b1, 8'h42, 16'h0007, 1'b0, 8'h00, 1'b0}}},
    '{POL_SPARE, '{1'b1, '{1'b0, 8'h00, 16'h0000, 16'h0000, 16'h0002},
                         '{1'b0, 8'h00, 16'h0000, 1'b1, 8'h42, 1'b0}}},
    // Round robin with time left queues the newcomer and leaves the slot idle.
    '{POL_RR, '{1'b1, '{1'b1, 8'h10, 16'h0003, 16'h0004, 16'h0000},
                      '{1'b0, 8'h00, 16'h0000, 1'b0, 8'h00, 1'b0}}},
    '{POL_RR, '{1'b1, '{1'b0, 8'h00, 16'h0000, 16'h0000, 16'h5555},
                      '{1'b0, 8'h00, 16'h0000, 1'b0, 8'h00, 1'b0}}},
    // First come first served takes the newcomer although entries wait.
    '{POL_FCFS, '{1'b1, '{1'b1, 8'h20, 16'h0006, 16'h0001, 16'h0000},
                        '{1'b1, 8'h20, 16'h0006, 1'b0, 8'h00, 1'b0}}},
    '{POL_RR, '{1'b0, '{1'b1, 8'h12, 16'h0005, 16'h0000, 16'h0001}, NO_RES}},
    '{POL_RR, '{1'b0, '{1'b0, 8'h00, 16'h0000, 16'h0000, 16'h0000}, NO_RES}},
    '{POL_RR, '{1'b0, '{1'b1, 8'h13, 16'hFFFF, 16'h0000, 16'hFFFF}, NO_RES}},
    '{POL_RR, '{1'b0, '{1'b0, 8'h00, 16'h0000, 16'h0000, 16'h0000}, NO_RES}},
    '{POL_RR, '{1'b0, '{1'b0, 8'h00, 16'h0000, 16'h0000, 16'h0002}, NO_RES}},
    '{POL_RR, '{1'b0, '{1'b0, 8'h00, 16'h0000, 16'h0000, 16'h0000}, NO_RES}},
    // Shortest remaining time: preemption, ties after equal bursts, zero burst.
    '{POL_SRTF, '{1'b0, '{1'b1, 8'h30, 16'h0008, 16'h0000, 16'h0000}, NO_RES}},
    '{POL_SRTF, '{1'b0, '{1'b1, 8'h31, 16'h0003, 16'h0005, 16'h0008}, NO_RES}},
    '{POL_SRTF, '{1'b0, '{1'b1, 8'h32, 16'h0008, 16'h0002, 16'h0003}, NO_RES}},
    '{POL_SRTF, '{1'b0, '{1'b1, 8'h33, 16'h0008, 16'h0009, 16'h0003}, NO_RES}},
    '{POL_SRTF, '{1'b0, '{1'b0, 8'h00, 16'h0000, 16'h0000, 16'h0000}, NO_RES}},
    '{POL_SRTF, '{1'b0, '{1'b1, 8'h34, 16'h0000, 16'h0000, 16'h0000}, NO_RES}},
    '{POL_SRTF, '{1'b0, '{1'b1, 8'h35, 16'h0001, 16'h0001, 16'h0000}, NO_RES}},
    '{POL_SRTF, '{1'b0, '{1'b0, 8'h00, 16'h0000, 16'h0000, 16'h0000}, NO_RES}},
    '{POL_SRTF, '{1'b0, '{1'b0, 8'hA5, 16'h5A5A, 16'hFFFF, 16'hFFFF}, NO_RES}}
  };

  process_ready_queue_scheduler u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  // Gap before the next word: mostly none or short, now and then long.
  function automatic int unsigned pick_gap(bit steady);
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // A 16-bit value biased toward the extremes and small numbers, so ties are common.
  function automatic logic [BURST_W-1:0] pick_word16();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4, 5: return BURST_W'($urandom_range(0, 7));
      default: return BURST_W'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // Queue operations of the predictor; a full queue drops the entry and flags it.
  function automatic void enqueue_tail(entry_t e);
    if (ready_q.size() >= QUEUE_DEPTH) drop_flag = 1'b1;
    else ready_q.push_back(e);
  endfunction

  function automatic void enqueue_by_burst(entry_t e);
    int unsigned pos;
    pos = 0;
    if (ready_q.size() >= QUEUE_DEPTH) begin
      drop_flag = 1'b1;
    end else begin
      while (pos < ready_q.size() && ready_q[pos].burst <= e.burst) pos++;
      ready_q.insert(pos, e);
    end
  endfunction

  function automatic void dispatch_front();
    if (ready_q.size() == 0) begin
      slot_busy = 1'b0;
    end else begin
      slot_busy = 1'b1;
      slot      = ready_q.pop_front();
    end
  endfunction

  // Predicts the outcome of one event and advances the predicted state.
  function automatic sched_result_t schedule_event(sched_event_t ev);
    sched_result_t   r;
    entry_t          incoming;
    logic            done;
    logic [ID_W-1:0] done_id;
    incoming  = '{id: ev.new_id, burst: ev.new_burst};
    done      = 1'b0;
    done_id   = '0;
    drop_flag = 1'b0;
    if (slot_busy) slot.burst = ev.run_burst;
    case (cur_policy)
      POL_RR: begin
        if (ev.time_left == 0) begin
          if (!slot_busy) begin
            if (ev.has_new) begin
              slot_busy = 1'b1;
              slot      = incoming;
            end
          end else begin
            if (ev.has_new) enqueue_tail(incoming);
            // An expired process with work left goes to the back of the queue.
            if (slot.burst != 0) begin
              enqueue_tail(slot);
            end else begin
              done    = 1'b1;
              done_id = slot.id;
            end
            dispatch_front();
          end
        end else if (ev.has_new) begin
          enqueue_tail(incoming);
        end
      end
      POL_SRTF: begin
        if (!ev.has_new) begin
          if (ev.time_left == 0 && slot_busy) begin
            done    = 1'b1;
            done_id = slot.id;
            dispatch_front();
          end
        end else if (ev.time_left == 0 && !slot_busy) begin
          slot_busy = 1'b1;
          slot      = incoming;
        end else begin
          if (ev.time_left == 0) begin
            done      = 1'b1;
            done_id   = slot.id;
            slot_busy = 1'b0;
          end
          // The newcomer preempts when its burst is below the time remaining.
          if (ev.time_left > ev.new_burst) begin
            if (slot_busy) enqueue_by_burst(slot);
            slot_busy = 1'b1;
            slot      = incoming;
          end else begin
            enqueue_by_burst(incoming);
            if (!slot_busy) dispatch_front();
          end
        end
      end
      default: begin
        if (!slot_busy) begin
          if (ev.has_new) begin
            slot_busy = 1'b1;
            slot      = incoming;
          end
        end else begin
          if (ev.has_new) enqueue_tail(incoming);
          if (ev.time_left == 0) begin
            done    = 1'b1;
            done_id = slot.id;
            dispatch_front();
          end
        end
      end
    endcase
    r.run_valid = slot_busy;
    r.run_id    = slot_busy ? slot.id : '0;
    r.run_burst = slot_busy ? slot.burst : '0;
    r.fin_valid = done;
    r.fin_id    = done_id;
    r.overflow  = drop_flag;
    return r;
  endfunction

  function automatic void check_field(string fld, logic [15:0] want_v, logic [15:0] got_v);
    if (want_v !== got_v) begin
      n_fail++;
      if (n_reports < MAX_REPORTS) begin
        n_reports++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, fld, want_v, got_v);
      end
    end
  endfunction

  // Watch all three channels: apply writes, predict events, check results.
  always @(posedge clk_i) begin : bus_monitor
    sched_result_t got;
    sched_result_t want;
    sched_rec_t    rec;
    sched_result_t pred;
    if (cfg_valid_i && cfg_ready_o) cur_policy = cfg_data_i;
    if (m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      got = '{m_axis_tuser[0], m_axis_tdata[7:0], m_axis_tdata[23:8],
              m_axis_tuser[1], m_axis_tdata[31:24], m_axis_tdata[32]};
      if (pending_outcomes.size() == 0) begin
        n_fail++;
        if (n_reports < MAX_REPORTS) begin
          n_reports++;
          $display("%0t: result word with no event pending, got %h", $time, got);
        end
      end else begin
        want = pending_outcomes.pop_front();
        check_field("run_valid", 16'(want.run_valid), 16'(got.run_valid));
        check_field("run_id", 16'(want.run_id), 16'(got.run_id));
        check_field("run_burst", want.run_burst, got.run_burst);
        check_field("finished_valid", 16'(want.fin_valid), 16'(got.fin_valid));
        check_field("finished_id", 16'(want.fin_id), 16'(got.fin_id));
        check_field("overflow", 16'(want.overflow), 16'(got.overflow));
      end
      check_field("padding", 16'd0, {9'd0, m_axis_tdata[39:33]});
    end
    if (s_axis_tvalid && s_axis_tready) begin
      rec  = offered_events.pop_front();
      pred = schedule_event(rec.ev);
      pending_outcomes.push_back(rec.typed ? rec.res : pred);
    end
    if ((cfg_valid_i && cfg_ready_o) || (m_axis_tvalid && m_axis_tready) ||
        (s_axis_tvalid && s_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
  end

  // A run that stops moving is a failure.
  initial begin : watchdog
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : result_sink
    int unsigned gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (SINK_HOLD) @(posedge clk_i);
      end
      gap = pick_gap(rx_steady);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Offers one event word and returns at the edge where it is taken.
  task automatic send_event(sched_event_t ev, logic typed, sched_result_t res);
    int unsigned gap;
    gap = pick_gap(tx_steady);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    offered_events.push_back('{typed, ev, res});
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ev.run_burst, ev.time_left, ev.new_burst, ev.new_id};
    s_axis_tuser  <= ev.has_new;
    do @(posedge clk_i); while (!s_axis_tready);
    events_sent++;
  endtask

  // Waits until every event has produced its result and the block is idle.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (events_sent != results_seen);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_policy(logic [POLICY_W-1:0] pol);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= pol;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned         i;
    int unsigned         j;
    int unsigned         k;
    int unsigned         seg_len;
    int unsigned         per_phase;
    logic [POLICY_W-1:0] pol_order [RAND_PHASES];
    logic [POLICY_W-1:0] tmp_pol;
    logic [POLICY_W-1:0] applied_pol;
    bit                  pol_written;
    load_mode_e          mode;
    sched_event_t        ev;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table; the policy is rewritten whenever a row asks for another one.
    pol_written = 1'b0;
    applied_pol = POL_FCFS;
    for (i = 0; i < DIR_ROWS; i++) begin
      if (!pol_written || dir_tab[i].pol != applied_pol) begin
        settle();
        write_policy(dir_tab[i].pol);
        applied_pol = dir_tab[i].pol;
        pol_written = 1'b1;
      end
      send_event(dir_tab[i].rec.ev, dir_tab[i].rec.typed, dir_tab[i].rec.res);
    end

    // Random phases: every policy code once in shuffled order, then a few more.
    pol_order[0] = POL_FCFS;
    pol_order[1] = POL_RR;
    pol_order[2] = POL_SRTF;
    pol_order[3] = POL_SPARE;
    for (i = 3; i > 0; i--) begin
      j            = $urandom_range(0, i);
      tmp_pol      = pol_order[i];
      pol_order[i] = pol_order[j];
      pol_order[j] = tmp_pol;
    end
    for (i = 4; i < RAND_PHASES; i++) begin
      pol_order[i] = POLICY_W'($urandom_range(POL_FCFS, POL_SPARE));
    end

    per_phase = RAND_ITEMS / RAND_PHASES;
    for (i = 0; i < RAND_PHASES; i++) begin
      settle();
      write_policy(pol_order[i]);
      // Long receiver hold-off once, so the block fills up and stalls its input.
      if (i == 1) sink_hold_req = 1'b1;
      k = 0;
      while (k < per_phase) begin
        // Segments that fill the queue, drain it, or mix both.
        mode      = load_mode_e'($urandom_range(LOAD_FILL, LOAD_MIX));
        seg_len   = $urandom_range(6, 30);
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
        for (j = 0; j < seg_len && k < per_phase; j++) begin
          case (mode)
            LOAD_FILL: begin
              ev.has_new   = ($urandom_range(0, 9) != 0);
              ev.time_left = ($urandom_range(0, 7) == 0) ? '0 : pick_word16();
            end
            LOAD_DRAIN: begin
              ev.has_new   = ($urandom_range(0, 6) == 0);
              ev.time_left = ($urandom_range(0, 3) != 0) ? '0 : pick_word16();
            end
            default: begin
              ev.has_new   = ($urandom_range(0, 1) != 0);
              ev.time_left = ($urandom_range(0, 2) == 0) ? '0 : pick_word16();
            end
          endcase
          ev.new_id    = ID_W'($urandom_range(0, 255));
          ev.new_burst = pick_word16();
          ev.run_burst = pick_word16();
          send_event(ev, 1'b0, NO_RES);
          k++;
        end
      end
    end

    tx_steady = 1'b0;
    rx_steady = 1'b0;
    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== process_ready_queue_scheduler.f =====
+incdir+hdl
hdl/prqs_pkg.sv
hdl/prqs_queue.sv
hdl/process_ready_queue_scheduler.sv
hdl/prqs_checker.sv
verif/tb_process_ready_queue_scheduler.sv
